// ----- design/bmbd_pkg.sv -----
// Shared constants and command codes for the box dilation mask block.
`timescale 1ns / 1ps
`default_nettype none

package bmbd_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int RADIUS_DEF     = 4;

	// mask word held in one memory entry
	localparam int WORD_W     = 64;
	localparam int WORD_OFF_W = $clog2(WORD_W);

	localparam int CMD_W      = 2;
	localparam int POS_X_W    = 11;
	localparam int POS_Y_W    = 10;
	localparam int FRAME_W_W  = 12;
	localparam int FRAME_H_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int FRAME_W_RST = 2048;
	localparam int FRAME_H_RST = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

endpackage

`default_nettype wire

// ----- design/binary_mask_box_dilation.sv -----
// Top level of the box dilation ink mask: command decode, window sequencing, two mask banks.
`timescale 1ns / 1ps
`default_nettype none

// The mask is held as 64-bit row words split over two RAM banks (even and odd word
// index), so the two words covering a window row are read together in one cycle.
// A query inside the frame reads the clipped window (at most 2*RADIUS+1 rows) one
// row per cycle from the banks. A write reads, modifies and writes back one word;
// a query outside the frame goes straight to its result. No new item is accepted
// until the current one is done. A clear command, and reset, run a clearing sweep
// over all BANK_DEPTH entries of each bank (16384 with default parameters)
// during which no item is accepted; configuration writes are always taken.
// A result waits in an output register; a query that finishes while the previous
// result is still waiting holds in its last cycle, and so holds off the next item,
// until that result is taken.
module binary_mask_box_dilation
	import bmbd_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int RADIUS     = RADIUS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic [POS_X_W-1:0]    pos_x,
	input  wire logic [POS_Y_W-1:0]    pos_y,
	input  wire logic                  ink_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       ink_out,
	output logic                       out_of_frame
);

	localparam int XB      = $clog2(MAX_WIDTH);
	localparam int WB      = $clog2(MAX_WIDTH + 1);
	localparam int XS      = XB + 1;
	localparam int YB      = $clog2(MAX_HEIGHT);
	localparam int HB      = $clog2(MAX_HEIGHT + 1);
	localparam int YS      = YB + 1;
	localparam int WIN     = 2 * RADIUS + 1;
	localparam int WX_BITS = (XB > WORD_OFF_W) ? XB - WORD_OFF_W : 1;
	localparam int G_W     = YB + WX_BITS;
	localparam int ADDR_W  = G_W - 1;
	localparam int BANK_DEPTH = 2 ** ADDR_W;

	localparam int FWC = (WB > FRAME_W_W) ? WB : FRAME_W_W;
	localparam int FHC = (HB > FRAME_H_W) ? HB : FRAME_H_W;
	localparam int PXC = (WB > POS_X_W) ? WB : POS_X_W;
	localparam int PYC = (HB > POS_Y_W) ? HB : POS_Y_W;

	localparam int AW_RST = (FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RST;
	localparam int AH_RST = (FRAME_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_H_RST;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_Q_RD,
		ST_Q_LAST,
		ST_Q_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [WB-1:0]       aw_q;
	logic [HB-1:0]       ah_q;
	logic [WX_BITS-1:0]  ws_q;
	logic [WORD_OFF_W-1:0] sh_q;
	logic [YB-1:0]       ry_q;
	logic [YB-1:0]       y_end_q;
	logic [WIN-1:0]      colmask_q;
	logic                ink_q;
	logic                hit_q;
	logic                oof_q;
	logic                rdv_s1;
	logic                out_valid_q;
	logic                ink_out_q;
	logic                oof_out_q;

	// configuration values
	logic [FRAME_W_W-1:0] fw_val;
	logic [FRAME_H_W-1:0] fh_val;

	// window setup
	logic             in_frame;
	logic [XS-1:0]    xi, x_lo, x_hi_raw, x_hi, x_base, cols;
	logic [YS-1:0]    yi, y_lo, y_hi_raw, y_hi, y_base;
	logic [WIN-1:0]   colmask_d;
	logic             is_write;

	// memory side
	logic [G_W-1:0]     g, g1;
	logic [ADDR_W-1:0]  a0, a1, addr0, addr1;
	logic               we0, we1;
	logic [WORD_W-1:0]  rd0, rd1, lower, upper, wword, wd;
	logic [2*WORD_W-1:0] pair, shifted;
	logic               row_hit;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign ink_out      = ink_out_q;
	assign out_of_frame = oof_out_q;

	assign fw_val = cfg_data[FRAME_W_W-1:0];
	assign fh_val = cfg_data[FRAME_H_W-1:0];

	always_comb begin
		in_frame = (PXC'(pos_x) < PXC'(aw_q)) && (PYC'(pos_y) < PYC'(ah_q));
		is_write = (cmd == CMD_WRITE);

		xi       = XS'(pos_x);
		x_lo     = (xi >= XS'(RADIUS)) ? xi - XS'(RADIUS) : '0;
		x_hi_raw = xi + XS'(RADIUS);
		x_hi     = (x_hi_raw < XS'(aw_q)) ? x_hi_raw : XS'(aw_q) - XS'(1);
		cols     = x_hi - x_lo + XS'(1);
		x_base   = is_write ? xi : x_lo;

		yi       = YS'(pos_y);
		y_lo     = (yi >= YS'(RADIUS)) ? yi - YS'(RADIUS) : '0;
		y_hi_raw = yi + YS'(RADIUS);
		y_hi     = (y_hi_raw < YS'(ah_q)) ? y_hi_raw : YS'(ah_q) - YS'(1);
		y_base   = is_write ? yi : y_lo;

		for (int i = 0; i < WIN; i++) begin
			colmask_d[i] = (XS'(i) < cols);
		end
	end

	// lower word of a pair sits in bank ws[0]; bank 0 takes the rounded-up address
	always_comb begin
		g  = {ry_q, ws_q};
		g1 = g + G_W'(1);
		a1 = ADDR_W'(g >> 1);
		a0 = ADDR_W'(g1 >> 1);

		lower   = ws_q[0] ? rd1 : rd0;
		upper   = ws_q[0] ? rd0 : rd1;
		pair    = {upper, lower};
		shifted = pair >> sh_q;
		row_hit = |(shifted[WIN-1:0] & colmask_q);

		wword       = lower;
		wword[sh_q] = ink_q;

		if (state_q == ST_CLEAR) begin
			addr0 = cnt_q;
			addr1 = cnt_q;
			we0   = 1'b1;
			we1   = 1'b1;
			wd    = '0;
		end else begin
			addr0 = a0;
			addr1 = a1;
			we0   = (state_q == ST_WR_WB) && !ws_q[0];
			we1   = (state_q == ST_WR_WB) && ws_q[0];
			wd    = wword;
		end
	end

	bmbd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BANK_DEPTH)
	) u_bank0 (
		.clk  (clk),
		.we   (we0),
		.addr (addr0),
		.wdata(wd),
		.rdata(rd0)
	);

	bmbd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BANK_DEPTH)
	) u_bank1 (
		.clk  (clk),
		.we   (we1),
		.addr (addr1),
		.wdata(wd),
		.rdata(rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			aw_q        <= WB'(AW_RST);
			ah_q        <= HB'(AH_RST);
			ws_q        <= '0;
			sh_q        <= '0;
			ry_q        <= '0;
			y_end_q     <= '0;
			colmask_q   <= '0;
			ink_q       <= 1'b0;
			hit_q       <= 1'b0;
			oof_q       <= 1'b0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			ink_out_q   <= 1'b0;
			oof_out_q   <= 1'b0;
		end else begin
			// clamp frame size on write
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					if (fw_val == '0) begin
						aw_q <= WB'(1);
					end else if (FWC'(fw_val) > FWC'(MAX_WIDTH)) begin
						aw_q <= WB'(MAX_WIDTH);
					end else begin
						aw_q <= WB'(fw_val);
					end
				end else if (cfg_index == REG_FRAME_HEIGHT) begin
					if (fh_val == '0) begin
						ah_q <= HB'(1);
					end else if (FHC'(fh_val) > FHC'(MAX_HEIGHT)) begin
						ah_q <= HB'(MAX_HEIGHT);
					end else begin
						ah_q <= HB'(fh_val);
					end
				end
			end

			rdv_s1 <= (state_q == ST_Q_RD);
			if (rdv_s1) begin
				hit_q <= hit_q | row_hit;
			end

			// a finishing query reloads the output register itself
			if (out_valid_q && out_ready && (state_q != ST_Q_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(BANK_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						ws_q      <= WX_BITS'(x_base >> WORD_OFF_W);
						sh_q      <= WORD_OFF_W'(x_base);
						ry_q      <= YB'(y_base);
						y_end_q   <= YB'(y_hi);
						colmask_q <= colmask_d;
						ink_q     <= ink_in;
						hit_q     <= 1'b0;
						case (cmd)
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_WRITE: begin
								if (in_frame) begin
									state_q <= ST_WR_RD;
								end
							end
							CMD_QUERY: begin
								oof_q   <= !in_frame;
								state_q <= in_frame ? ST_Q_RD : ST_Q_DONE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_WB;
				end
				ST_WR_WB: begin
					state_q <= ST_IDLE;
				end
				ST_Q_RD: begin
					if (ry_q == y_end_q) begin
						state_q <= ST_Q_LAST;
					end else begin
						ry_q <= ry_q + YB'(1);
					end
				end
				ST_Q_LAST: begin
					// last row is folded in by the accumulate above
					state_q <= ST_Q_DONE;
				end
				ST_Q_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ink_out_q   <= hit_q && !oof_q;
						oof_out_q   <= oof_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/bmbd_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bmbd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for the box dilation ink mask: directed table, then randomized frame phases.
`timescale 1ns / 1ps

module tb_top;
	import bmbd_pkg::*;

	localparam int MW           = MAX_WIDTH_DEF;
	localparam int MH           = MAX_HEIGHT_DEF;
	localparam int R            = RADIUS_DEF;
	localparam int CLEAR_CYCLES = MH * (MW / WORD_W) / 2;
	localparam int SEGMENTS     = 8;
	localparam int SEG_ITEMS    = 215;
	localparam int PLAN_ROWS    = 35;

	localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic ink;
		logic oof;
	} px_result_t;

	// cfg rows use code as register index and a as data; item rows use a as x and b as y
	typedef struct {
		bit              is_cfg;
		logic [CMD_W-1:0] code;
		logic [11:0]     a;
		logic [9:0]      b;
		logic            ink;
		bit              typed;
		logic            e_ink;
		logic            e_oof;
	} step_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [POS_X_W-1:0]    pos_x;
	logic [POS_Y_W-1:0]    pos_y;
	logic                  ink_in;
	logic                  out_valid;
	logic                  out_ready;
	logic                  ink_out;
	logic                  out_of_frame;

	binary_mask_box_dilation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.ink_in       (ink_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ink_out      (ink_out),
		.out_of_frame (out_of_frame)
	);

	// mirror of the mask: only inked pixels are present, keyed by y * MW + x
	bit               ink_px [int unsigned];
	logic [11:0]      width_reg;
	logic [10:0]      height_reg;
	px_result_t       px_expected [$];
	px_result_t       head_px;

	int send_idle;
	int recv_stall;
	bit last_clear;
	int mismatches;
	int n_items;
	int n_query;
	int n_ink;
	int n_oof;
	int n_clear;
	int n_cfg;

	step_row_t plan [0:PLAN_ROWS-1] = '{
		'{1'b0, CMD_QUERY, 12'd0,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_WRITE, 12'd2047, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd2043, 10'd1019, 1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, CMD_QUERY, 12'd2042, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_WRITE, 12'd0,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd4,    10'd4,    1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, CMD_QUERY, 12'd0,    10'd5,    1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_SPARE, 12'd4,    10'd5,    1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd0,    10'd5,    1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_WRITE, 12'd0,    10'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd2,    10'd2,    1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, REG_FRAME_WIDTH,  12'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_FRAME_HEIGHT, 12'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_WRITE, 12'd1,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_WRITE, 12'd0,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd0,    10'd0,    1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, CMD_QUERY, 12'd1,    10'd0,    1'b0, 1'b1, 1'b0, 1'b1},
		'{1'b1, REG_FRAME_WIDTH,  12'hFFF, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_FRAME_HEIGHT, 12'hFFF, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd5,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd2047, 10'd1023, 1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b1, REG_FRAME_WIDTH,  12'd16, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_FRAME_HEIGHT, 12'd16, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd15,   10'd15,   1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd16,   10'd0,    1'b0, 1'b1, 1'b0, 1'b1},
		'{1'b0, CMD_WRITE, 12'd15,   10'd15,   1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd12,   10'd12,   1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_SPARE_A, 12'hFFF, 10'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_SPARE_B, 12'h000, 10'd0,   1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd16,   10'd16,   1'b0, 1'b1, 1'b0, 1'b1},
		'{1'b1, REG_FRAME_WIDTH,  12'd2048, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_FRAME_HEIGHT, 12'd1024, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd19,   10'd19,   1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_CLEAR, 12'd0,    10'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CMD_QUERY, 12'd2047, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0}
	};

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic dilate_window(int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		int unsigned x0, x1, y0, y1, xx, yy;
		x0 = (x >= R) ? x - R : 0;
		y0 = (y >= R) ? y - R : 0;
		x1 = (x + R < w) ? x + R : w - 1;
		y1 = (y + R < h) ? y + R : h - 1;
		for (yy = y0; yy <= y1; yy++)
			for (xx = x0; xx <= x1; xx++)
				if (ink_px.exists(yy * MW + xx))
					return 1'b1;
		return 1'b0;
	endfunction

	// 0: item ignored, 1: mask updated only, 2: one result expected in res
	function automatic int predict_mask_step(logic [CMD_W-1:0] op, logic [POS_X_W-1:0] x,
			logic [POS_Y_W-1:0] y, logic ink, output px_result_t res);
		int unsigned w, h, key;
		bit in_frame;
		w = clamp_dim(width_reg, MW);
		h = clamp_dim(height_reg, MH);
		in_frame = (x < w) && (y < h);
		key = int'(y) * MW + int'(x);
		res = '{1'b0, 1'b0};
		case (op)
		CMD_CLEAR: begin
			ink_px.delete();
			return 1;
		end
		CMD_WRITE: begin
			if (!in_frame)
				return 0;
			if (ink)
				ink_px[key] = 1'b1;
			else
				ink_px.delete(key);
			return 1;
		end
		CMD_QUERY: begin
			if (in_frame)
				res.ink = dilate_window(x, y, w, h);
			else
				res.oof = 1'b1;
			return 2;
		end
		default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic send_item(logic [CMD_W-1:0] op, logic [POS_X_W-1:0] x,
			logic [POS_Y_W-1:0] y, logic ink, bit typed, logic e_ink, logic e_oof);
		px_result_t res;
		int kind;
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		pos_x    <= x;
		pos_y    <= y;
		ink_in   <= ink;
		do @(posedge clk); while (!in_ready);
		kind = predict_mask_step(op, x, y, ink, res);
		if (kind == 2) begin
			if (typed)
				res = '{e_ink, e_oof};
			px_expected = {px_expected, res};
			n_query++;
			n_ink += res.ink;
			n_oof += res.oof;
		end
		if (kind != 0)
			n_items++;
		if (op == CMD_CLEAR)
			n_clear++;
		last_clear = (op == CMD_CLEAR);
	endtask

	// drop valid, wait for every pending result, then let the block settle
	task automatic quiesce(int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (px_expected.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		quiesce(last_clear ? CLEAR_CYCLES + 32 : 32);
		last_clear = 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_FRAME_WIDTH:  width_reg = data;
		REG_FRAME_HEIGHT: height_reg = data[10:0];
		default: ;
		endcase
		n_cfg++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (px_expected.size() == 0) begin
				report_mismatch("result with no query pending", ink_out, 0);
			end else begin
				head_px = px_expected.pop_front();
				if (ink_out !== head_px.ink)
					report_mismatch("ink_out", ink_out, head_px.ink);
				if (out_of_frame !== head_px.oof)
					report_mismatch("out_of_frame", out_of_frame, head_px.oof);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int seg, k, roll, pick, px, py, cx, cy, xl, yl, aw, ah;
		int ink_pct, clear_permil, seg_start;
		logic [CMD_W-1:0] op;
		logic [CFG_DATA_W-1:0] w_set, h_set;
		bit small_frame;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_FRAME_WIDTH;
		cfg_data   = '0;
		in_valid   = 1'b0;
		cmd        = CMD_CLEAR;
		pos_x      = '0;
		pos_y      = '0;
		ink_in     = 1'b0;
		send_idle  = 12;
		recv_stall = 12;
		last_clear = 1'b0;
		width_reg  = FRAME_W_W'(FRAME_W_RST);
		height_reg = FRAME_H_W'(FRAME_H_RST);
		ink_px.delete();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].code, plan[i].a);
			else
				send_item(plan[i].code, plan[i].a[10:0], plan[i].b, plan[i].ink,
					plan[i].typed, plan[i].e_ink, plan[i].e_oof);
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
			0: begin w_set = 12'd2048; h_set = 12'd1024; end
			1: begin w_set = 12'd0;    h_set = 12'd0;    end
			2: begin w_set = 12'd16;   h_set = 12'd9;    end
			3: begin w_set = 12'hFFF;  h_set = 12'hFFF;  end
			4: begin
				w_set = CFG_DATA_W'($urandom_range(1, 64));
				h_set = CFG_DATA_W'($urandom_range(1, 64));
			end
			5: begin w_set = 12'd1;    h_set = 12'd1024; end
			6: begin w_set = 12'd2048; h_set = 12'd1;    end
			default: begin
				w_set = CFG_DATA_W'($urandom_range(0, 4095));
				h_set = CFG_DATA_W'($urandom_range(0, 4095));
			end
			endcase
			write_reg(REG_FRAME_WIDTH, w_set);
			write_reg(REG_FRAME_HEIGHT, h_set);
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
				CFG_DATA_W'($urandom()));

			case (seg % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 78; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 78; end
			default: begin send_idle = 12; recv_stall = 12; end
			endcase

			aw = clamp_dim(width_reg, MW);
			ah = clamp_dim(height_reg, MH);
			xl = (aw > 2047) ? 2047 : aw;
			yl = (ah > 1023) ? 1023 : ah;
			small_frame  = (aw * ah < 4096);
			ink_pct      = small_frame ? 15 : 40;
			clear_permil = small_frame ? 14 : 3;
			seg_start = n_items;
			k = 0;
			cx = 0;
			cy = 0;
			while (n_items - seg_start < SEG_ITEMS) begin
				// move the ink cluster now and then so writes and queries overlap
				if (k % 32 == 0) begin
					cx = $urandom_range(0, aw - 1);
					cy = $urandom_range(0, ah - 1);
				end
				roll = $urandom_range(999);
				if (roll < clear_permil)
					op = CMD_CLEAR;
				else if (roll < 40)
					op = CMD_SPARE;
				else if (roll < 520)
					op = CMD_WRITE;
				else
					op = CMD_QUERY;
				pick = $urandom_range(99);
				if (pick < 15) begin
					px = $urandom_range(0, 2047);
					py = $urandom_range(0, 1023);
				end else if (pick < 50) begin
					px = $urandom_range(0, xl);
					py = $urandom_range(0, yl);
				end else begin
					px = cx + int'($urandom_range(0, 20)) - 10;
					py = cy + int'($urandom_range(0, 12)) - 6;
					px = (px < 0) ? 0 : (px > xl) ? xl : px;
					py = (py < 0) ? 0 : (py > yl) ? yl : py;
				end
				send_item(op, px[10:0], py[9:0], $urandom_range(99) < ink_pct,
					1'b0, 1'b0, 1'b0);
				// hold off until the pipe is empty once in a while
				if (k % 150 == 149)
					quiesce(0);
				k++;
			end
		end

		quiesce(64);
		$display("covered %0d items: %0d queries (%0d ink, %0d outside frame), %0d clears",
			n_items, n_query, n_ink, n_oof, n_clear);
		$display("over %0d register writes, frames from 1x1 to full size, with gaps and stalls",
			n_cfg);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
design/bmbd_pkg.sv
design/bmbd_ram.sv
design/binary_mask_box_dilation.sv
test/tb_top.sv
